/* rtl/core/mzr_pkg.sv */
`timescale 1ns / 1ps

package mzr_pkg;

   // input item kinds (req_tuser)
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_SYMBOL = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ALPHA = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_BYTE_MAP_0   = 3'd0;
   localparam logic [2:0] CSR_BYTE_MAP_1   = 3'd1;
   localparam logic [2:0] CSR_BYTE_MAP_2   = 3'd2;
   localparam logic [2:0] CSR_BYTE_MAP_3   = 3'd3;
   localparam logic [2:0] CSR_BLOCK_LEVEL  = 3'd4;

   localparam logic [3:0] LEVEL_MIN   = 4'd1;
   localparam logic [3:0] LEVEL_MAX   = 4'd9;
   localparam logic [3:0] LEVEL_RESET = 4'd9;
   localparam logic [19:0] RUN_UNIT   = 20'd100000;
   localparam logic [19:0] RUN_MAX    = 20'd900000;

   // highest run symbol (RUNB)
   localparam logic [8:0] SYM_RUNB = 9'd1;

   // weight shift at which the run weight saturates, and the counter ceiling
   localparam logic [4:0] WEIGHT_SAT = 5'd21;
   localparam logic [4:0] SHIFT_MAX  = 5'd31;

   // list read tree: cells per registered group
   localparam int GROUP_SIZE = 16;

   // result queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;

   typedef struct packed {
      logic [7:0]  value;
      logic [19:0] repeat_res;
      logic [1:0]  status;
      logic        last;
   } result_type;

   // per-cycle command broadcast to every list cell
   typedef struct packed {
      logic       shift;   // move entries toward the tail this cycle
      logic [8:0] limit;   // highest cell index that moves
      logic [7:0] head;    // value loaded into cell 0
      logic [8:0] rd_pos;  // cell index to read out
   } list_ctrl_type;

   function automatic logic [19:0] run_limit(input logic [3:0] level);
      logic [3:0] lv;
      lv = level;
      if (lv < LEVEL_MIN) lv = LEVEL_MIN;
      if (lv > LEVEL_MAX) lv = LEVEL_MAX;
      run_limit = 20'(24'(lv) * 24'(RUN_UNIT));
   endfunction

endpackage

/* rtl/core/mzr_cell.sv */
`timescale 1ns / 1ps

module mzr_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  mzr_pkg::list_ctrl_type ctrl,
   input  logic [7:0]            prev_value,
   output logic [7:0]            value,
   output logic [7:0]            rd_value
);

   logic [7:0] value_ff;
   logic       move;
   logic       hit;

   assign move     = ctrl.shift && (9'(INDEX) <= ctrl.limit);
   assign hit      = (ctrl.rd_pos == 9'(INDEX));
   assign value    = value_ff;
   assign rd_value = hit ? value_ff : 8'd0;

   // take the neighbor's entry when this cell is inside the moving span
   always_ff @(posedge clock) begin
      if (move) begin
         value_ff <= prev_value;
      end
   end

endmodule

/* rtl/core/mzr_list.sv */
`timescale 1ns / 1ps

module mzr_list #(
   parameter int ALPHABET_BYTES = 256
) (
   input  logic                   clock,
   input  mzr_pkg::list_ctrl_type ctrl,
   output logic [7:0]             head_value,
   output logic [7:0]             rd_data
);

   localparam int GROUPS = (ALPHABET_BYTES + mzr_pkg::GROUP_SIZE - 1) / mzr_pkg::GROUP_SIZE;
   localparam int PADDED = GROUPS * mzr_pkg::GROUP_SIZE;

   logic [7:0] cell_value [ALPHABET_BYTES];
   logic [7:0] masked     [PADDED];
   logic [7:0] grp_in     [GROUPS];
   logic [7:0] grp_ff     [GROUPS];

   genvar i;
   generate
      for (i = 0; i < PADDED; i++) begin : g_cell
         if (i < ALPHABET_BYTES) begin : g_real
            logic [7:0] prev;
            if (i == 0) begin : g_first
               assign prev = ctrl.head;
            end else begin : g_rest
               assign prev = cell_value[i-1];
            end
            mzr_cell #(.INDEX(i)) u_cell (
               .clock      (clock),
               .ctrl       (ctrl),
               .prev_value (prev),
               .value      (cell_value[i]),
               .rd_value   (masked[i])
            );
         end else begin : g_pad
            assign masked[i] = 8'd0;
         end
      end
   endgenerate

   assign head_value = cell_value[0];

   // first tree level: OR the one-hot masked cells of each group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = 8'd0;
         for (int k = 0; k < mzr_pkg::GROUP_SIZE; k++) begin
            grp_in[g] = grp_in[g] | masked[g*mzr_pkg::GROUP_SIZE + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   always_comb begin
      rd_data = 8'd0;
      for (int g = 0; g < GROUPS; g++) begin
         rd_data = rd_data | grp_ff[g];
      end
   end

endmodule

/* rtl/core/mtf_zero_run_decoder.sv */
`timescale 1ns / 1ps
// Steps: a symbol or end beat passes accept, list read through the registered group tree and
//   execute; its results enter a 4-deep result queue that drives rsp.
// A new beat is taken only when idle with room for two results; a start beat runs a seeding
//   sweep that visits one byte value per cycle and shifts the in-use ones into the cell chain.
// Reset (synchronous, active high): clears the run, list count, queue and byte map, and sets
//   block_level to 9; list cells hold garbage until the next start beat seeds them.
module mtf_zero_run_decoder #(
   parameter int ALPHABET_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] symbol, [15:9] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] value, [27:8] repeat_res, [29:28] status, [31:30] 0
   output logic        rsp_tlast,   // last result of the input beat
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int IDX_W = (ALPHABET_BYTES > 1) ? $clog2(ALPHABET_BYTES) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SEED = 4'b0010,
      S_READ = 4'b0100,
      S_EXEC = 4'b1000
   } state_type;

   // ---------------------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------------------
   logic [63:0] byte_map_ff [4];
   logic [3:0]  block_level_ff;
   logic [255:0] map_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < 4; m++) byte_map_ff[m] <= 64'd0;
         block_level_ff <= mzr_pkg::LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mzr_pkg::CSR_BYTE_MAP_0:  byte_map_ff[0] <= csr_wdata;
            mzr_pkg::CSR_BYTE_MAP_1:  byte_map_ff[1] <= csr_wdata;
            mzr_pkg::CSR_BYTE_MAP_2:  byte_map_ff[2] <= csr_wdata;
            mzr_pkg::CSR_BYTE_MAP_3:  byte_map_ff[3] <= csr_wdata;
            mzr_pkg::CSR_BLOCK_LEVEL: block_level_ff <= csr_wdata[3:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   assign map_all = {byte_map_ff[3], byte_map_ff[2], byte_map_ff[1], byte_map_ff[0]};

   // ---------------------------------------------------------------------------------------------
   // Control and run state
   // ---------------------------------------------------------------------------------------------
   state_type   state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [8:0]  sym_ff, sym_in;
   logic [IDX_W-1:0] seed_idx_ff, seed_idx_in;
   logic [8:0]  used_ff, used_in;
   logic [20:0] run_total_ff, run_total_in;
   logic [4:0]  run_shift_ff, run_shift_in;
   logic        run_pending_ff, run_pending_in;

   // result queue
   mzr_pkg::result_type q_ff [mzr_pkg::Q_DEPTH];
   logic [mzr_pkg::Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [mzr_pkg::Q_PTR_W:0]   count_ff;
   logic        pop;
   logic [1:0]  push_cnt;
   mzr_pkg::result_type res_a, res_b;

   // list chain
   mzr_pkg::list_ctrl_type ctrl;
   logic [7:0]  head_value;
   logic [7:0]  rd_data;

   // execute-step intermediates
   logic        accept;
   logic        seed_bit;
   logic [8:0]  pos;
   logic [21:0] add;
   logic [21:0] sum;
   logic [19:0] limit;

   assign req_tready = (state_ff == S_IDLE) && (count_ff <= 3'(mzr_pkg::Q_DEPTH - 2));
   assign accept     = req_tvalid && req_tready;
   assign pos        = sym_ff - 9'd1;
   assign seed_bit   = map_all[8'(seed_idx_ff)];
   assign limit      = mzr_pkg::run_limit(block_level_ff);

   always_comb begin
      if (run_shift_ff >= mzr_pkg::WEIGHT_SAT) begin
         add = 22'd1 << 21;
      end else begin
         add = (22'd1 << run_shift_ff) << sym_ff[0];
      end
      sum = {1'b0, run_total_ff} + add;
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      sym_in         = sym_ff;
      seed_idx_in    = seed_idx_ff;
      used_in        = used_ff;
      run_total_in   = run_total_ff;
      run_shift_in   = run_shift_ff;
      run_pending_in = run_pending_ff;
      push_cnt       = 2'd0;
      res_a          = '0;
      res_b          = '0;
      ctrl.shift     = 1'b0;
      ctrl.limit     = pos;
      ctrl.head      = rd_data;
      ctrl.rd_pos    = pos;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_tuser;
               sym_in  = req_tdata[8:0];
               if (req_tuser == mzr_pkg::KIND_START) begin
                  // drop any pending run and restart the list from the top byte down
                  run_total_in   = 21'd0;
                  run_shift_in   = 5'd0;
                  run_pending_in = 1'b0;
                  used_in        = 9'd0;
                  seed_idx_in    = IDX_W'(ALPHABET_BYTES - 1);
                  state_in       = S_SEED;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         S_SEED: begin
            // push each in-use byte into the head; sweeping downward leaves ascending order
            ctrl.shift = seed_bit;
            ctrl.limit = 9'h1FF;
            ctrl.head  = 8'(seed_idx_ff);
            used_in    = used_ff + 9'(seed_bit);
            seed_idx_in = seed_idx_ff - IDX_W'(1);
            if (seed_idx_ff == '0) begin
               state_in = S_IDLE;
               if (used_in == 9'd0) begin
                  res_a.status = mzr_pkg::ST_EMPTY;
                  push_cnt     = 2'd1;
               end
            end
         end

         S_READ: begin
            // group tree captures the entry at pos this cycle
            state_in = S_EXEC;
         end

         S_EXEC: begin
            state_in = S_IDLE;
            case (kind_ff)
               mzr_pkg::KIND_SYMBOL: begin
                  if (used_ff == 9'd0) begin
                     res_a.status = mzr_pkg::ST_EMPTY;
                     push_cnt     = 2'd1;
                  end else if (sym_ff <= mzr_pkg::SYM_RUNB) begin
                     if (sum > {2'b00, limit}) begin
                        // run too long: report it and start over
                        res_a.status   = mzr_pkg::ST_RUN;
                        push_cnt       = 2'd1;
                        run_total_in   = 21'd0;
                        run_shift_in   = 5'd0;
                        run_pending_in = 1'b0;
                     end else begin
                        run_total_in   = sum[20:0];
                        run_pending_in = 1'b1;
                        if (run_shift_ff < mzr_pkg::SHIFT_MAX) begin
                           run_shift_in = run_shift_ff + 5'd1;
                        end
                     end
                  end else begin
                     // flush the pending run of the current head first
                     if (run_pending_ff) begin
                        res_a.value      = head_value;
                        res_a.repeat_res = run_total_ff[19:0];
                        res_a.status     = mzr_pkg::ST_OK;
                        run_total_in     = 21'd0;
                        run_shift_in     = 5'd0;
                        run_pending_in   = 1'b0;
                     end
                     if (pos >= used_ff) begin
                        res_b.status = mzr_pkg::ST_ALPHA;
                     end else begin
                        res_b.value      = rd_data;
                        res_b.repeat_res = 20'd1;
                        res_b.status     = mzr_pkg::ST_OK;
                        ctrl.shift       = 1'b1;
                     end
                     if (run_pending_ff) begin
                        push_cnt = 2'd2;
                     end else begin
                        res_a    = res_b;
                        push_cnt = 2'd1;
                     end
                  end
               end
               mzr_pkg::KIND_END: begin
                  if (run_pending_ff && (used_ff != 9'd0)) begin
                     res_a.value      = head_value;
                     res_a.repeat_res = run_total_ff[19:0];
                     res_a.status     = mzr_pkg::ST_OK;
                     push_cnt         = 2'd1;
                  end
                  run_total_in   = 21'd0;
                  run_shift_in   = 5'd0;
                  run_pending_in = 1'b0;
               end
               default: ;  // unused kind: no result, no change
            endcase
         end

         default: state_in = S_IDLE;
      endcase

      // mark the final result of this beat
      if (push_cnt == 2'd2) begin
         res_b.last = 1'b1;
      end else begin
         res_a.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         used_ff        <= 9'd0;
         run_total_ff   <= 21'd0;
         run_shift_ff   <= 5'd0;
         run_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         run_total_ff   <= run_total_in;
         run_shift_ff   <= run_shift_in;
         run_pending_ff <= run_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sym_ff      <= sym_in;
      seed_idx_ff <= seed_idx_in;
   end

   mzr_list #(.ALPHABET_BYTES(ALPHABET_BYTES)) u_list (
      .clock      (clock),
      .ctrl       (ctrl),
      .head_value (head_value),
      .rd_data    (rd_data)
   );

   // ---------------------------------------------------------------------------------------------
   // Result queue: up to two pushes per cycle, one pop
   // ---------------------------------------------------------------------------------------------
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {2'b00, q_ff[rd_ptr_ff].status, q_ff[rd_ptr_ff].repeat_res,
                        q_ff[rd_ptr_ff].value};
   assign rsp_tlast  = q_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= res_a;
      end
      if (push_cnt == 2'd2) begin
         q_ff[wr_ptr_ff + mzr_pkg::Q_PTR_W'(1)] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + mzr_pkg::Q_PTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + mzr_pkg::Q_PTR_W'(pop);
         count_ff  <= count_ff + (mzr_pkg::Q_PTR_W + 1)'(push_cnt)
                      - (mzr_pkg::Q_PTR_W + 1)'(pop);
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(mzr_pkg::Q_DEPTH))
      else $error("result queue overflow");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= 9'(ALPHABET_BYTES))
      else $error("list count beyond alphabet");

   a_idle_run_clear: assert property (@(posedge clock) disable iff (reset)
      !run_pending_ff |-> (run_total_ff == 21'd0) && (run_shift_ff == 5'd0))
      else $error("run state left without a pending run");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_total_ff <= {1'b0, mzr_pkg::RUN_MAX})
      else $error("run total beyond largest block");

   a_exec_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_IDLE))
      else $error("execute step did not return to idle");

endmodule

/* tb/tb_mtf_zero_run_decoder.sv */
`timescale 1ns / 1ps

module tb_mtf_zero_run_decoder;

   localparam int ALPHABET = 256;
   // a start beat sweeps the whole alphabet; allow that plus the pipe and result queue
   localparam int DRAIN_CYCLES = ALPHABET + 32;
   localparam int PHASES = 9;
   localparam logic [1:0] KIND_NONE = 2'd3;   // reserved kind, the block drops it
   localparam logic [8:0] SYM_RUNA = 9'd0;

   typedef struct packed {
      logic [1:0] kind;
      logic [8:0] symbol;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [8:0] symbol, [15:9] zero
   logic [1:0]  req_tuser = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [7:0] value, [27:8] repeat_res, [29:28] status, [31:30] 0
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // stimulus and scoreboard
   beat_type   beat_q[$];
   beat_type   cur_beat;
   mzr_pkg::result_type expected_runs[$];
   mzr_pkg::result_type got_run;
   mzr_pkg::result_type want_run;
   bit         req_open = 1'b0;
   int         tx_idle_pct = 7;
   int         rx_idle_pct = 70;
   int         items_queued = 0;
   int         beats_in = 0;
   int         runs_out = 0;
   int         fail_count = 0;
   int         status_tally[4] = '{0, 0, 0, 0};

   // shadow of the block: register file, list and run accumulator
   logic [63:0] map_shadow[4] = '{64'd0, 64'd0, 64'd0, 64'd0};
   logic [3:0]  level_shadow = mzr_pkg::LEVEL_RESET;
   logic [7:0]  mtf_order[ALPHABET];
   int          list_len = 0;
   int          run_sum = 0;
   int          run_shift = 0;
   bit          run_armed = 1'b0;

   mtf_zero_run_decoder #(
      .ALPHABET_BYTES(ALPHABET)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic mzr_pkg::result_type make_run(input logic [7:0] value, input int rep,
                                                    input logic [1:0] status);
      mzr_pkg::result_type r;
      r.value = value;
      r.repeat_res = 20'(rep);
      r.status = status;
      r.last = 1'b0;
      return r;
   endfunction

   // Work out the result beats of one accepted input beat and queue them.
   task automatic decode_beat(input logic [1:0] kind, input logic [8:0] sym);
      mzr_pkg::result_type res[2];
      int n;
      int add;
      int pos;
      int lv;
      logic [7:0] ch;
      n = 0;
      lv = (level_shadow < mzr_pkg::LEVEL_MIN) ? int'(mzr_pkg::LEVEL_MIN) :
           (level_shadow > mzr_pkg::LEVEL_MAX) ? int'(mzr_pkg::LEVEL_MAX) :
           int'(level_shadow);
      case (kind)
         mzr_pkg::KIND_START: begin
            // reseed in ascending byte order; a pending run is dropped silently
            run_sum = 0;
            run_shift = 0;
            run_armed = 1'b0;
            list_len = 0;
            for (int b = 0; b < ALPHABET; b++) begin
               if (map_shadow[b / 64][b % 64]) begin
                  mtf_order[list_len] = 8'(b);
                  list_len++;
               end
            end
            if (list_len == 0) begin
               res[n] = make_run(8'd0, 0, mzr_pkg::ST_EMPTY);
               n++;
            end
         end
         mzr_pkg::KIND_SYMBOL: begin
            if (list_len == 0) begin
               res[n] = make_run(8'd0, 0, mzr_pkg::ST_EMPTY);
               n++;
            end else if (sym <= mzr_pkg::SYM_RUNB) begin
               // RUNA adds the weight, RUNB twice the weight, then the weight doubles until it saturates
               if (run_shift >= int'(mzr_pkg::WEIGHT_SAT)) add = 1 << mzr_pkg::WEIGHT_SAT;
               else add = (1 << run_shift) << ((sym == mzr_pkg::SYM_RUNB) ? 1 : 0);
               if (run_sum + add > lv * int'(mzr_pkg::RUN_UNIT)) begin
                  res[n] = make_run(8'd0, 0, mzr_pkg::ST_RUN);
                  n++;
                  run_sum = 0;
                  run_shift = 0;
                  run_armed = 1'b0;
               end else begin
                  run_sum += add;
                  if (run_shift < int'(mzr_pkg::SHIFT_MAX)) run_shift++;
                  run_armed = 1'b1;
               end
            end else begin
               pos = int'(sym) - 1;
               if (run_armed) begin
                  res[n] = make_run(mtf_order[0], run_sum, mzr_pkg::ST_OK);
                  n++;
                  run_sum = 0;
                  run_shift = 0;
                  run_armed = 1'b0;
               end
               if (pos >= list_len) begin
                  res[n] = make_run(8'd0, 0, mzr_pkg::ST_ALPHA);
                  n++;
               end else begin
                  ch = mtf_order[pos];
                  res[n] = make_run(ch, 1, mzr_pkg::ST_OK);
                  n++;
                  for (int i = pos; i > 0; i--) mtf_order[i] = mtf_order[i - 1];
                  mtf_order[0] = ch;
               end
            end
         end
         mzr_pkg::KIND_END: begin
            if (run_armed && list_len != 0) begin
               res[n] = make_run(mtf_order[0], run_sum, mzr_pkg::ST_OK);
               n++;
            end
            run_sum = 0;
            run_shift = 0;
            run_armed = 1'b0;
         end
         default: ;
      endcase
      if (n > 0) res[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_runs.push_back(res[i]);
   endtask

   // ------------------------------------------------------------------
   // Driver: present the next beat at the falling edge, hold it until taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_open) begin
         if (beat_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            cur_beat = beat_q.pop_front();
            req_tdata <= {7'd0, cur_beat.symbol};
            req_tuser <= cur_beat.kind;
            req_tvalid <= 1'b1;
            req_open = 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Predict at the edge where the input beat is taken.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         decode_beat(req_tuser, req_tdata[8:0]);
         req_open = 1'b0;
         beats_in++;
      end
   end

   // Receiver back-pressure: toggle ready at random on the falling edge.
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: compare each taken result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         runs_out++;
         got_run.value = rsp_tdata[7:0];
         got_run.repeat_res = rsp_tdata[27:8];
         got_run.status = rsp_tdata[29:28];
         got_run.last = rsp_tlast;
         status_tally[got_run.status]++;
         if (expected_runs.size() == 0) begin
            $error("unexpected result beat: value %0d repeat %0d status %0d",
                   got_run.value, got_run.repeat_res, got_run.status);
            fail_count++;
         end else begin
            want_run = expected_runs.pop_front();
            check_field("value", int'(want_run.value), int'(got_run.value));
            check_field("repeat_res", int'(want_run.repeat_res), int'(got_run.repeat_res));
            check_field("status", int'(want_run.status), int'(got_run.status));
            check_field("last", int'(want_run.last), int'(got_run.last));
            check_field("pad", 0, int'(rsp_tdata[31:30]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_item(input logic [1:0] kind, input logic [8:0] sym);
      beat_q.push_back('{kind: kind, symbol: sym});
      if (kind != KIND_NONE) items_queued++;
   endtask

   // Mostly valid list positions, biased toward the head, plus some out of range.
   function automatic logic [8:0] pick_symbol(input int n);
      int r;
      int top;
      r = $urandom_range(99);
      if (n == 0 || r < 6) return 9'($urandom_range(511));
      if (r < 11) return 9'(n + 1 + $urandom_range(3, 1));
      top = (r < 55 && n > 4) ? 5 : n + 1;
      return 9'($urandom_range(top, 2));
   endfunction

   // One block: start, a mix of zero runs, list symbols, an occasional reserved beat or restart, then usually an end.
   task automatic queue_frame(input int n);
      int frame_len;
      int seg;
      int r;
      int i;
      frame_len = $urandom_range(40, 6);
      queue_item(mzr_pkg::KIND_START, 9'($urandom_range(511)));
      i = 0;
      while (i < frame_len) begin
         r = $urandom_range(99);
         if (r < 40) begin
            // long runs are rare but must reach the block-size limit
            seg = ($urandom_range(99) < 12) ? $urandom_range(21, 14) : $urandom_range(4, 1);
            repeat (seg) queue_item(mzr_pkg::KIND_SYMBOL, 9'($urandom_range(1)));
            i += seg;
         end else if (r < 94) begin
            queue_item(mzr_pkg::KIND_SYMBOL, pick_symbol(n));
            i++;
         end else if (r < 97) begin
            queue_item(KIND_NONE, 9'($urandom_range(511)));
            i++;
         end else begin
            queue_item(mzr_pkg::KIND_START, 9'($urandom_range(511)));
            i++;
         end
      end
      if ($urandom_range(99) < 90) queue_item(mzr_pkg::KIND_END, 9'($urandom_range(511)));
   endtask

   // Wait until every beat is taken and every result seen, then let the block go idle.
   task automatic settle();
      while (beat_q.size() != 0 || req_open || expected_runs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         mzr_pkg::CSR_BYTE_MAP_0: map_shadow[0] = data;
         mzr_pkg::CSR_BYTE_MAP_1: map_shadow[1] = data;
         mzr_pkg::CSR_BYTE_MAP_2: map_shadow[2] = data;
         mzr_pkg::CSR_BYTE_MAP_3: map_shadow[3] = data;
         mzr_pkg::CSR_BLOCK_LEVEL: level_shadow = data[3:0];
         default: ;
      endcase
   endtask

   task automatic load_setting(input logic [63:0] m0, input logic [63:0] m1,
                               input logic [63:0] m2, input logic [63:0] m3,
                               input logic [3:0] level);
      write_csr(mzr_pkg::CSR_BYTE_MAP_0, m0);
      write_csr(mzr_pkg::CSR_BYTE_MAP_1, m1);
      write_csr(mzr_pkg::CSR_BYTE_MAP_2, m2);
      write_csr(mzr_pkg::CSR_BYTE_MAP_3, m3);
      write_csr(mzr_pkg::CSR_BLOCK_LEVEL, 64'(level));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [63:0] m[4];
      logic [3:0]  level;
      int          n;
      int          target;
      int          b;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list straight out of reset: symbols and start flag the empty map, end is silent
      queue_item(mzr_pkg::KIND_SYMBOL, 9'd2);
      queue_item(mzr_pkg::KIND_SYMBOL, SYM_RUNA);
      queue_item(mzr_pkg::KIND_END, 9'd0);
      queue_item(mzr_pkg::KIND_START, 9'd0);
      settle();

      // list of 66 entries: bytes 0..63, 192 and 255
      load_setting({64{1'b1}}, 64'd0, 64'd0, 64'h8000_0000_0000_0001, mzr_pkg::LEVEL_MAX);
      @(posedge clock);
      queue_item(mzr_pkg::KIND_START, 9'd0);
      queue_item(mzr_pkg::KIND_SYMBOL, SYM_RUNA);
      queue_item(mzr_pkg::KIND_SYMBOL, mzr_pkg::SYM_RUNB);
      queue_item(mzr_pkg::KIND_SYMBOL, 9'd2);      // flush run of byte 0, then byte 1
      queue_item(mzr_pkg::KIND_SYMBOL, 9'd66);     // tail entry, byte 255
      queue_item(mzr_pkg::KIND_SYMBOL, 9'd67);     // one past the list
      queue_item(mzr_pkg::KIND_SYMBOL, SYM_RUNA);
      queue_item(mzr_pkg::KIND_SYMBOL, 9'd257);    // flush, then beyond alphabet
      queue_item(mzr_pkg::KIND_SYMBOL, 9'd511);
      queue_item(mzr_pkg::KIND_SYMBOL, mzr_pkg::SYM_RUNB);
      queue_item(mzr_pkg::KIND_START, 9'd0);       // drop the pending run
      queue_item(mzr_pkg::KIND_END, 9'd0);         // nothing pending
      queue_item(KIND_NONE, 9'd3);
      queue_item(mzr_pkg::KIND_SYMBOL, SYM_RUNA);
      queue_item(mzr_pkg::KIND_END, 9'd0);         // flush a one-long run

      for (int p = 0; p < PHASES; p++) begin
         settle();
         m = '{64'd0, 64'd0, 64'd0, 64'd0};
         case (p)
            0: begin
               m = '{{64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}};
               level = mzr_pkg::LEVEL_MIN;
            end
            1: begin
               foreach (m[k]) m[k] = rand64();
               level = mzr_pkg::LEVEL_MAX;
            end
            2: begin
               b = $urandom_range(255);
               m[b / 64] = 64'd1 << (b % 64);
               level = 4'd0;
            end
            3: level = 4'd15;
            4: begin
               foreach (m[k]) m[k] = rand64() & rand64() & rand64();
               level = 4'($urandom_range(15));
            end
            5: begin
               m[0] = 64'd1;
               m[3] = 64'h8000_0000_0000_0000;
               level = 4'($urandom_range(15));
            end
            6: begin
               m = '{{64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}};
               level = mzr_pkg::LEVEL_MAX;
            end
            8: begin
               foreach (m[k]) m[k] = ~(rand64() & rand64());
               level = 4'd2;
            end
            default: begin
               foreach (m[k]) m[k] = rand64();
               level = 4'($urandom_range(15));
            end
         endcase
         load_setting(m[0], m[1], m[2], m[3], level);
         n = $countones(m[0]) + $countones(m[1]) + $countones(m[2]) + $countones(m[3]);

         @(posedge clock);
         // slow receiver first, then slow sender, then full rate
         if (p < 3) begin
            tx_idle_pct = 7;
            rx_idle_pct = 70;
         end else if (p < 6) begin
            tx_idle_pct = 70;
            rx_idle_pct = 7;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         target = items_queued + ((n == 0) ? 40 : 115);
         while (items_queued < target) queue_frame(n);
      end

      settle();
      $display("Covered %0d input beats and %0d result beats over %0d register settings",
               beats_in, runs_out, PHASES + 1);
      $display("Result status mix: ok %0d, beyond alphabet %0d, run overflow %0d, empty map %0d",
               status_tally[mzr_pkg::ST_OK], status_tally[mzr_pkg::ST_ALPHA],
               status_tally[mzr_pkg::ST_RUN], status_tally[mzr_pkg::ST_EMPTY]);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop in case a handshake hangs.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
